[rtl/core/dapd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapd_pkg: shared types and constants of the dual-axis PID drive
// Field widths, fixed-point formats, register indexes and direction codes.
// ----------------------------------------------------------------------------
package dapd_pkg;

    localparam int AXES            = 2;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int PROD_SHIFT      = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

    localparam int ANGLE_W = 16;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int SUM_W   = 21;
    localparam int DE_W    = ERR_W + 1;
    localparam int GAIN_W  = 20;
    localparam int ILIM_W  = 20;
    localparam int OLIM_W  = 16;
    localparam int GLIM_W  = 15;
    localparam int DRIVE_W = OLIM_W + 1;
    localparam int PP_W    = GAIN_W + 1 + ERR_W;
    localparam int PI_W    = GAIN_W + 1 + SUM_W;
    localparam int PD_W    = GAIN_W + 1 + DE_W;
    localparam int ACC_W   = PI_W + 1;
    localparam int MAG_W   = ACC_W - PROD_SHIFT;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 20'd15360;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 20'd202;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 20'd204800;
    localparam logic [ILIM_W-1:0] ILIM_RST   = 20'd588800;
    localparam logic [OLIM_W-1:0] OLIM_RST   = 16'd2400;
    localparam logic [GLIM_W-1:0] GLIM_RST   = 15'd11520;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_GATE_ENABLE    = 3'd5,
        REG_GATE_LIMIT     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

endpackage

[rtl/core/dual_axis_pid_drive_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_axis_pid_drive_unit: two-axis positional PID drive
// Pipeline: stage 1, stage 2 and the result register (three register stages).
// Throughput: one request per cycle unless stalled; the integrator closes in stage 1.
// The whole pipe stalls together while a finished result waits on m_ready.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// integrals and previous errors, and empties the pipe.
// ----------------------------------------------------------------------------
module dual_axis_pid_drive_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [dapd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dapd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [dapd_pkg::ANGLE_W-1:0] s_target_x,
    input  logic signed [dapd_pkg::ANGLE_W-1:0] s_measured_x,
    input  logic signed [dapd_pkg::ANGLE_W-1:0] s_target_y,
    input  logic signed [dapd_pkg::ANGLE_W-1:0] s_measured_y,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dapd_pkg::DRIVE_W-1:0] m_drive_x,
    output logic signed [dapd_pkg::DRIVE_W-1:0] m_drive_y,
    output logic [1:0]                        m_dir_x,
    output logic [1:0]                        m_dir_y,
    output logic [dapd_pkg::OLIM_W-1:0]       m_magnitude_x,
    output logic [dapd_pkg::OLIM_W-1:0]       m_magnitude_y
);

    localparam int AXES    = dapd_pkg::AXES;
    localparam int ANGLE_W = dapd_pkg::ANGLE_W;
    localparam int ERR_W   = dapd_pkg::ERR_W;
    localparam int SUM_W   = dapd_pkg::SUM_W;
    localparam int DE_W    = dapd_pkg::DE_W;
    localparam int GAIN_W  = dapd_pkg::GAIN_W;
    localparam int ILIM_W  = dapd_pkg::ILIM_W;
    localparam int OLIM_W  = dapd_pkg::OLIM_W;
    localparam int GLIM_W  = dapd_pkg::GLIM_W;
    localparam int DRIVE_W = dapd_pkg::DRIVE_W;
    localparam int PP_W    = dapd_pkg::PP_W;
    localparam int PI_W    = dapd_pkg::PI_W;
    localparam int PD_W    = dapd_pkg::PD_W;
    localparam int ACC_W   = dapd_pkg::ACC_W;
    localparam int MAG_W   = dapd_pkg::MAG_W;
    localparam int SHIFT   = dapd_pkg::PROD_SHIFT;
    localparam int RAW_W   = SUM_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [ILIM_W-1:0] integral_limit_reg;
    logic [OLIM_W-1:0] output_limit_reg;
    logic              gate_enable_reg;
    logic [GLIM_W-1:0] gate_limit_reg;

    // Decode the index; drop writes beyond the register list and the
    // data bits above each register's width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= dapd_pkg::GAIN_P_RST;
            gain_i_reg         <= dapd_pkg::GAIN_I_RST;
            gain_d_reg         <= dapd_pkg::GAIN_D_RST;
            integral_limit_reg <= dapd_pkg::ILIM_RST;
            output_limit_reg   <= dapd_pkg::OLIM_RST;
            gate_enable_reg    <= 1'b0;
            gate_limit_reg     <= dapd_pkg::GLIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dapd_pkg::REG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_W-1:0];
                dapd_pkg::REG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_W-1:0];
                dapd_pkg::REG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                dapd_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[ILIM_W-1:0];
                dapd_pkg::REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[OLIM_W-1:0];
                dapd_pkg::REG_GATE_ENABLE:    gate_enable_reg    <= cfg_data[0];
                dapd_pkg::REG_GATE_LIMIT:     gate_limit_reg     <= cfg_data[GLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: every stage moves together when the result register
    // is empty or being taken.
    // ------------------------------------------------------------------
    logic advance;
    logic accept;
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Stage 1: error, clamped integral, derivative; update axis state
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] target   [AXES];
    logic signed [ANGLE_W-1:0] measured [AXES];

    assign target[0]   = s_target_x;
    assign measured[0] = s_measured_x;
    assign target[1]   = s_target_y;
    assign measured[1] = s_measured_y;

    logic signed [SUM_W-1:0] error_sum_reg      [AXES];
    logic signed [ERR_W-1:0] previous_error_reg [AXES];

    logic signed [ERR_W-1:0] err_next  [AXES];
    logic signed [RAW_W-1:0] raw_sum   [AXES];
    logic signed [SUM_W-1:0] sum_next  [AXES];
    logic signed [DE_W-1:0]  de_next   [AXES];
    logic [ANGLE_W-1:0]      meas_abs  [AXES];
    logic signed [RAW_W-1:0] lim_pos;
    logic signed [RAW_W-1:0] lim_neg;
    logic                    blocked_next;

    assign lim_pos = $signed({{(RAW_W-ILIM_W){1'b0}}, integral_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb begin
        blocked_next = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            err_next[a] = $signed({target[a][ANGLE_W-1], target[a]})
                        - $signed({measured[a][ANGLE_W-1], measured[a]});
            raw_sum[a]  = $signed({error_sum_reg[a][SUM_W-1], error_sum_reg[a]})
                        + $signed({{(RAW_W-ERR_W){err_next[a][ERR_W-1]}}, err_next[a]});
            // Clamp to +/- limit; a lowered limit pulls the integral back here.
            if (raw_sum[a] > lim_pos) begin
                sum_next[a] = lim_pos[SUM_W-1:0];
            end else if (raw_sum[a] < lim_neg) begin
                sum_next[a] = lim_neg[SUM_W-1:0];
            end else begin
                sum_next[a] = raw_sum[a][SUM_W-1:0];
            end
            de_next[a]  = $signed({err_next[a][ERR_W-1], err_next[a]})
                        - $signed({previous_error_reg[a][ERR_W-1], previous_error_reg[a]});
            meas_abs[a] = measured[a][ANGLE_W-1] ? ANGLE_W'(-measured[a])
                                                 : ANGLE_W'(measured[a]);
            if (meas_abs[a] >= {{(ANGLE_W-GLIM_W){1'b0}}, gate_limit_reg}) begin
                blocked_next = gate_enable_reg;
            end
        end
    end

    logic                    s1_blocked_reg;
    logic signed [ERR_W-1:0] s1_err_reg [AXES];
    logic signed [SUM_W-1:0] s1_sum_reg [AXES];
    logic signed [DE_W-1:0]  s1_de_reg  [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                error_sum_reg[a]      <= '0;
                previous_error_reg[a] <= '0;
            end
        end else if (advance) begin
            s1_valid_reg <= accept;
            // Hold the state when gated off.
            if (accept && !blocked_next) begin
                for (int a = 0; a < AXES; a++) begin
                    error_sum_reg[a]      <= sum_next[a];
                    previous_error_reg[a] <= err_next[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_blocked_reg <= blocked_next;
            for (int a = 0; a < AXES; a++) begin
                s1_err_reg[a] <= err_next[a];
                s1_sum_reg[a] <= sum_next[a];
                s1_de_reg[a]  <= de_next[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gain products, one multiplier per term and axis, each registered
    // ------------------------------------------------------------------
    logic                   s2_blocked_reg;
    logic signed [PP_W-1:0] s2_pp_reg [AXES];
    logic signed [PI_W-1:0] s2_pi_reg [AXES];
    logic signed [PD_W-1:0] s2_pd_reg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_blocked_reg <= s1_blocked_reg;
            for (int a = 0; a < AXES; a++) begin
                s2_pp_reg[a] <= PP_W'($signed({1'b0, gain_p_reg}) * s1_err_reg[a]);
                s2_pi_reg[a] <= PI_W'($signed({1'b0, gain_i_reg}) * s1_sum_reg[a]);
                s2_pd_reg[a] <= PD_W'($signed({1'b0, gain_d_reg}) * s1_de_reg[a]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, truncate toward zero on the magnitude, saturate
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]   acc      [AXES];
    logic [ACC_W-1:0]          acc_abs  [AXES];
    logic [MAG_W-1:0]          mag_int  [AXES];
    logic [OLIM_W-1:0]         mag_sat  [AXES];
    logic signed [DRIVE_W-1:0] drive_next [AXES];
    logic [1:0]                dir_next   [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            acc[a]     = ACC_W'(s2_pp_reg[a]) + ACC_W'(s2_pi_reg[a]) + ACC_W'(s2_pd_reg[a]);
            acc_abs[a] = acc[a][ACC_W-1] ? ACC_W'(-acc[a]) : ACC_W'(acc[a]);
            mag_int[a] = acc_abs[a][ACC_W-1:SHIFT];
            if (s2_blocked_reg) begin
                mag_sat[a] = '0;
            end else if (mag_int[a] > {{(MAG_W-OLIM_W){1'b0}}, output_limit_reg}) begin
                mag_sat[a] = output_limit_reg;
            end else begin
                mag_sat[a] = mag_int[a][OLIM_W-1:0];
            end
            if (mag_sat[a] == '0) begin
                drive_next[a] = '0;
                dir_next[a]   = dapd_pkg::DIR_HOLD;
            end else if (acc[a][ACC_W-1]) begin
                drive_next[a] = -$signed({1'b0, mag_sat[a]});
                dir_next[a]   = dapd_pkg::DIR_NEG;
            end else begin
                drive_next[a] = $signed({1'b0, mag_sat[a]});
                dir_next[a]   = dapd_pkg::DIR_POS;
            end
        end
    end

    logic signed [DRIVE_W-1:0] drive_reg [AXES];
    logic [1:0]                dir_reg   [AXES];
    logic [OLIM_W-1:0]         mag_reg   [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int a = 0; a < AXES; a++) begin
                drive_reg[a] <= drive_next[a];
                dir_reg[a]   <= dir_next[a];
                mag_reg[a]   <= mag_sat[a];
            end
        end
    end

    assign m_drive_x     = drive_reg[0];
    assign m_drive_y     = drive_reg[1];
    assign m_dir_x       = dir_reg[0];
    assign m_dir_y       = dir_reg[1];
    assign m_magnitude_x = mag_reg[0];
    assign m_magnitude_y = mag_reg[1];

endmodule
